// ----- design/swfp_pkg.sv -----
// shared types and constants of the ssh wire field parser
`timescale 1ns / 1ps

package swfp_pkg;

    localparam int POS_BITS = 16;
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW = $clog2(CQ_DEPTH);
    localparam logic [7:0] COMMA_BYTE = 8'h2c;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;
    localparam logic [1:0] ACT_END = 2'd2;

    localparam logic [1:0] KIND_BOOL = 2'd0;
    localparam logic [1:0] KIND_LIST = 2'd3;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_BOOL = 3'd1;
    localparam logic [2:0] EV_DATA = 3'd2;
    localparam logic [2:0] EV_NAME = 3'd3;
    localparam logic [2:0] EV_DONE = 3'd4;
    localparam logic [2:0] EV_ERROR = 3'd5;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_TRUNC = 3'd1;
    localparam logic [2:0] ERR_EMPTY = 3'd2;
    localparam logic [2:0] ERR_TRAIL = 3'd3;
    localparam logic [2:0] ERR_MISUSE = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_LIST,
        PH_BOOL
    } phase_t;

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_BYTE,
        CMD_END,
        CMD_NOP
    } cmd_op_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] field_kind;
        logic [7:0] data_byte;
    } request_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic        bool_value;
        logic [15:0] data_start;
        logic [31:0] data_length;
        logic [2:0]  error_code;
    } result_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [1:0] kind;
        logic [7:0] data;
        logic       is_comma;
        logic       nonzero;
    } cmd_t;

endpackage

// ----- design/swfp_front.sv -----
// front end: request decode and command queue
`timescale 1ns / 1ps

module swfp_front
    import swfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);

    cmd_t             cq_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_AW:0]   count_reg, count_next;
    cmd_t             decoded;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        decoded.kind = request.field_kind;
        decoded.data = request.data_byte;
        decoded.is_comma = (request.data_byte == COMMA_BYTE);
        decoded.nonzero = (request.data_byte != 8'd0);
        unique case (request.action)
            ACT_BEGIN: decoded.op = CMD_BEGIN;
            ACT_BYTE:  decoded.op = CMD_BYTE;
            ACT_END:   decoded.op = CMD_END;
            default:   decoded.op = CMD_NOP;
        endcase
    end

    assign full = (count_reg == (CQ_AW + 1)'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd = cq_mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 1'b1 : 1'b0);
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cq_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ----- design/swfp_back.sv -----
// back end: field parser state machine and result queue
`timescale 1ns / 1ps

module swfp_back
    import swfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_take,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    phase_t              phase_reg, phase_next;
    logic [1:0]          kind_reg, kind_next;
    logic [31:0]         hbytes_reg, hbytes_next;
    logic [2:0]          hcount_reg, hcount_next;
    logic [31:0]         left_reg, left_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] fbegin_reg, fbegin_next;
    logic [POS_BITS-1:0] nbegin_reg, nbegin_next;

    logic [POS_BITS-1:0] pos_inc;
    logic [31:0]         hb_shift;
    logic [2:0]          hc_inc;
    logic [31:0]         left_dec;
    logic                left_zero;
    logic                name_empty;
    result_t             res;

    result_t             oq_mem [2];
    logic                oq_wr_reg, oq_rd_reg;
    logic [1:0]          oq_count_reg, oq_count_next;
    logic                oq_push;
    logic                oq_pop;

    assign pos_inc = pos_reg + 1'b1;
    assign hb_shift = {hbytes_reg[23:0], cmd.data};
    assign hc_inc = hcount_reg + 1'b1;
    assign left_dec = left_reg - 1'b1;
    assign left_zero = (left_dec == 32'd0);
    assign name_empty = (nbegin_reg == pos_reg);

    // state update
    always_comb
    begin
        phase_next = phase_reg;
        kind_next = kind_reg;
        hbytes_next = hbytes_reg;
        hcount_next = hcount_reg;
        left_next = left_reg;
        pos_next = pos_reg;
        fbegin_next = fbegin_reg;
        nbegin_next = nbegin_reg;
        unique case (cmd.op)
            CMD_BEGIN:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    kind_next = cmd.kind;
                    hbytes_next = '0;
                    hcount_next = '0;
                    left_next = '0;
                    phase_next = (cmd.kind == KIND_BOOL) ? PH_BOOL : PH_HEADER;
                end
            end
            CMD_BYTE:
            begin
                pos_next = pos_inc;
                unique case (phase_reg)
                    PH_BOOL:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_HEADER:
                    begin
                        hbytes_next = hb_shift;
                        hcount_next = hc_inc;
                        if (hc_inc >= 3'd4)
                        begin
                            fbegin_next = pos_inc;
                            nbegin_next = pos_inc;
                            left_next = hb_shift;
                            if (hb_shift == 32'd0)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (kind_reg == KIND_LIST)
                            begin
                                phase_next = PH_LIST;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        if (left_zero)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_LIST:
                    begin
                        left_next = left_dec;
                        if (cmd.is_comma)
                        begin
                            if (name_empty || left_zero)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                nbegin_next = pos_inc;
                            end
                        end
                        else if (left_zero)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            CMD_END:
            begin
                pos_next = '0;
                phase_next = PH_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    // result of the current command
    always_comb
    begin
        res = '0;
        unique case (cmd.op)
            CMD_BEGIN:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res.event_res = EV_ERROR;
                    res.error_code = ERR_MISUSE;
                end
            end
            CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_BOOL:
                    begin
                        res.event_res = EV_BOOL;
                        res.bool_value = cmd.nonzero;
                    end
                    PH_HEADER:
                    begin
                        if (hc_inc >= 3'd4 && hb_shift == 32'd0)
                        begin
                            res.event_res = (kind_reg == KIND_LIST) ? EV_DONE : EV_DATA;
                            res.data_start = 16'(pos_inc);
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (left_zero)
                        begin
                            res.event_res = EV_DATA;
                            res.data_start = 16'(fbegin_reg);
                            res.data_length = hbytes_reg;
                        end
                    end
                    PH_LIST:
                    begin
                        if (cmd.is_comma)
                        begin
                            if (name_empty)
                            begin
                                res.event_res = EV_ERROR;
                                res.error_code = ERR_EMPTY;
                            end
                            else if (left_zero)
                            begin
                                res.event_res = EV_ERROR;
                                res.error_code = ERR_TRAIL;
                            end
                            else
                            begin
                                res.event_res = EV_NAME;
                                res.data_start = 16'(nbegin_reg);
                                res.data_length = 32'(POS_BITS'(pos_reg - nbegin_reg));
                            end
                        end
                        else if (left_zero)
                        begin
                            res.event_res = EV_DONE;
                            res.data_start = 16'(nbegin_reg);
                            res.data_length = 32'(POS_BITS'(pos_inc - nbegin_reg));
                        end
                    end
                    default:
                    begin
                        res.event_res = EV_ERROR;
                        res.error_code = ERR_MISUSE;
                    end
                endcase
            end
            CMD_END:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res.event_res = EV_ERROR;
                    res.error_code = ERR_TRUNC;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result queue, two entries
    assign empty = (oq_count_reg == 2'd0);
    assign result = oq_mem[oq_rd_reg];
    assign oq_pop = pop && !empty;
    assign cmd_take = cmd_valid && ((oq_count_reg != 2'd2) || oq_pop);
    assign oq_push = cmd_take;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (oq_pop && !oq_push)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg <= '0;
            hbytes_reg <= '0;
            hcount_reg <= '0;
            left_reg <= '0;
            pos_reg <= '0;
            fbegin_reg <= '0;
            nbegin_reg <= '0;
            oq_wr_reg <= 1'b0;
            oq_rd_reg <= 1'b0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (cmd_take)
            begin
                phase_reg <= phase_next;
                kind_reg <= kind_next;
                hbytes_reg <= hbytes_next;
                hcount_reg <= hcount_next;
                left_reg <= left_next;
                pos_reg <= pos_next;
                fbegin_reg <= fbegin_next;
                nbegin_reg <= nbegin_next;
            end
            if (oq_push)
            begin
                oq_wr_reg <= ~oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= ~oq_rd_reg;
            end
            oq_count_reg <= oq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem[oq_wr_reg] <= res;
        end
    end

endmodule

// ----- design/ssh_wire_field_parser_top.sv -----
// top level of the ssh wire field parser
// usage:
//   input side is a queue: drive request and push; a request is taken on a
//   clock edge with push high and full low. each request is a begin of a
//   field (with its kind), one buffer byte, an end of buffer, or a no-op.
//   result side is a queue: while empty is low the oldest result sits on
//   result; it is taken on a clock edge with pop high and empty low.
//   every request yields exactly one result, in request order; most carry
//   event none, the rest report a boolean, a string or mpint, a name, the
//   end of a list or an error.
//   a request is registered into the command queue, and its result is
//   registered into the result queue when the parser takes the command;
//   the result can be popped once it sits on the result port.
//   throughput: one request per cycle while the result queue has room or is
//   being popped, set by the parser step that updates the length counter and position per byte.
//   a four-entry command queue feeds the parser, a two-entry result queue
//   follows it; when pop is held low the result queue fills, the parser
//   stops, and full rises once the command queue holds four requests.
//   reset clears both queues and puts the parser idle at buffer offset zero.
`timescale 1ns / 1ps

module ssh_wire_field_parser_top
    import swfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  request_t request,
    output logic     empty,
    input  logic     pop,
    output result_t  result
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    swfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    swfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
